// ----- design/mnpg_pkg.sv -----
// Shared types, codes and constants for the monophonic note priority and glide block.
// Used by every module in this folder; depends on nothing else.
package mnpg_pkg;

    localparam int STACK_DEPTH_DEF = 16;

    localparam int NOTE_W  = 7;
    localparam int LEVEL_W = 7;
    localparam int STEP_W  = 15;
    localparam int PITCH_W = 32;

    // Input action codes.
    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_ON   = 2'd1;
    localparam logic [1:0] ACT_OFF  = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_GLIDE_ON   = 1'b0;
    localparam logic CFG_GLIDE_STEP = 1'b1;

    localparam logic [STEP_W-1:0]  GLIDE_STEP_RST = 15'd26214;
    localparam logic [LEVEL_W-1:0] LEVEL_RST      = 7'd127;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TICK_RD,
        ST_TICK_LUT,
        ST_TICK_DIFF,
        ST_TICK_STEP,
        ST_SCAN,
        ST_SHIFT,
        ST_PUSH,
        ST_ON_WAIT,
        ST_ON_LUT,
        ST_DONE
    } seq_state_t;

    typedef struct packed {
        logic                glide_on;
        logic [STEP_W-1:0]   glide_step;
    } glide_cfg_t;

    typedef struct packed {
        logic [PITCH_W-1:0]  pitch_now;
        logic                gate;
        logic                trigger;
        logic                release_res;
        logic [LEVEL_W-1:0]  level;
    } result_t;

endpackage

// ----- design/mnpg_stack_mem.sv -----
// Held-note stack storage: one write port, one read port, registered read data.
// Depends on mnpg_pkg for the note width.
module mnpg_stack_mem
    import mnpg_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int AW          = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [NOTE_W-1:0] wdata,
    input  logic [AW-1:0]     raddr,
    output logic [NOTE_W-1:0] rdata
);

    logic [NOTE_W-1:0] held_notes_mem [STACK_DEPTH];
    logic [NOTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            held_notes_mem[waddr] <= wdata;
        end
        rdata_reg <= held_notes_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/mnpg_note_pitch.sv -----
// Two-stage note-to-pitch converter: octave and semitone split, then table and shift.
// Depends on mnpg_pkg for widths. The split and the pitch are each held in a register.
module mnpg_note_pitch
    import mnpg_pkg::*;
(
    input  logic               clk,
    input  logic [NOTE_W-1:0]  note,
    output logic [PITCH_W-1:0] pitch
);

    localparam int OCT_MAX = 10;

    // Top octave (notes 120..131) in Q14.18 Hz, rounded.
    function automatic logic [PITCH_W-1:0] top_octave(input logic [3:0] semi);
        logic [PITCH_W-1:0] v;
        case (semi)
            4'd0:    v = 32'd2194674310;
            4'd1:    v = 32'd2325176436;
            4'd2:    v = 32'd2463438621;
            4'd3:    v = 32'd2609922305;
            4'd4:    v = 32'd2765116361;
            4'd5:    v = 32'd2929538736;
            4'd6:    v = 32'd3103738174;
            4'd7:    v = 32'd3288296050;
            4'd8:    v = 32'd3483828309;
            4'd9:    v = 32'd3690987520;
            4'd10:   v = 32'd3910465059;
            4'd11:   v = 32'd4142993412;
            default: v = '0;
        endcase
        return v;
    endfunction

    logic [3:0]         oct_reg, oct_next;
    logic [3:0]         semi_reg, semi_next;
    logic [PITCH_W-1:0] pitch_reg, pitch_next;
    logic [3:0]         shift_amt;
    logic [PITCH_W:0]   rounded;

    // Stage one: the octave is the count of twelve-note boundaries at or below the note.
    always_comb
    begin
        oct_next = '0;
        for (int k = 1; k <= OCT_MAX; k++)
        begin
            if (int'(note) >= 12 * k)
            begin
                oct_next = 4'(k);
            end
        end
        semi_next = 4'(note - 7'(oct_next * 12));
    end

    // Stage two: scale the top-octave entry down with round to nearest, halves up.
    always_comb
    begin
        shift_amt = 4'(OCT_MAX) - oct_reg;
        rounded   = {1'b0, top_octave(semi_reg)};
        if (shift_amt != 4'd0)
        begin
            rounded = rounded + ((PITCH_W + 1)'(1) << (shift_amt - 4'd1));
        end
        pitch_next = PITCH_W'(rounded >> shift_amt);
    end

    always_ff @(posedge clk)
    begin
        oct_reg   <= oct_next;
        semi_reg  <= semi_next;
        pitch_reg <= pitch_next;
    end

    assign pitch = pitch_reg;

endmodule

// ----- design/mnpg_seq.sv -----
// Sequencer: read-modify-write of the held-note stack, glide arithmetic and result state.
// Depends on mnpg_pkg; drives mnpg_stack_mem and mnpg_note_pitch from the top level.
module mnpg_seq
    import mnpg_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int AW          = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         action,
    input  logic [NOTE_W-1:0]  note,
    input  logic [LEVEL_W-1:0] velocity,
    input  glide_cfg_t         cfg,
    input  logic               out_free,
    output logic               res_load,
    output result_t            res,
    output logic               mem_we,
    output logic [AW-1:0]      mem_waddr,
    output logic [NOTE_W-1:0]  mem_wdata,
    output logic [AW-1:0]      mem_raddr,
    input  logic [NOTE_W-1:0]  mem_rdata,
    output logic [NOTE_W-1:0]  lut_note,
    input  logic [PITCH_W-1:0] lut_pitch
);

    localparam int CW  = $clog2(STACK_DEPTH + 1);
    localparam int CWX = CW + 1;
    localparam logic [CWX-1:0] DEPTH_X = CWX'(STACK_DEPTH);

    seq_state_t         state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [PITCH_W-1:0] pitch_reg, pitch_next;
    logic [PITCH_W-1:0] target_reg, target_next;
    logic [PITCH_W-1:0] diff_reg, diff_next;
    logic               up_reg, up_next;
    logic [1:0]         action_reg, action_next;
    logic [NOTE_W-1:0]  note_reg, note_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic               trig_reg, trig_next;
    logic               rel_reg, rel_next;

    logic [CWX-1:0]     rd_ptr;
    logic [CWX-1:0]     idx_x;
    logic [CWX-1:0]     cnt_x;
    logic [PITCH_W-1:0] step_x;

    assign idx_x  = {1'b0, idx_reg};
    assign cnt_x  = {1'b0, count_reg};
    assign step_x = PITCH_W'(cfg.glide_step);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        pitch_next  = pitch_reg;
        target_next = target_reg;
        diff_next   = diff_reg;
        up_next     = up_reg;
        action_next = action_reg;
        note_next   = note_reg;
        level_next  = level_reg;
        trig_next   = trig_reg;
        rel_next    = rel_reg;
        in_ready    = 1'b0;
        res_load    = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = idx_reg[AW-1:0];
        mem_wdata   = mem_rdata;
        rd_ptr      = '0;
        lut_note    = note_reg;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    action_next = action;
                    note_next   = note;
                    trig_next   = 1'b0;
                    rel_next    = 1'b0;
                    idx_next    = '0;
                    case (action)
                        ACT_TICK:
                        begin
                            // Fetch the newest held note; an empty stack leaves the pitch alone.
                            rd_ptr = cnt_x - CWX'(1);
                            state_next = (count_reg != '0) ? ST_TICK_RD : ST_DONE;
                        end
                        ACT_ON:
                        begin
                            trig_next  = 1'b1;
                            level_next = velocity;
                            if (cnt_x == DEPTH_X)
                            begin
                                // Full: drop the oldest entry by shifting down from slot zero.
                                rd_ptr     = CWX'(1);
                                state_next = ST_SHIFT;
                            end
                            else
                            begin
                                state_next = ST_PUSH;
                            end
                        end
                        ACT_OFF:
                        begin
                            rd_ptr = '0;
                            if (count_reg == '0)
                            begin
                                rel_next   = 1'b1;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_TICK_RD:
            begin
                lut_note   = mem_rdata;
                state_next = ST_TICK_LUT;
            end

            ST_TICK_LUT:
            begin
                state_next = ST_TICK_DIFF;
            end

            ST_TICK_DIFF:
            begin
                target_next = lut_pitch;
                if (lut_pitch > pitch_reg)
                begin
                    diff_next = lut_pitch - pitch_reg;
                    up_next   = 1'b1;
                end
                else
                begin
                    diff_next = pitch_reg - lut_pitch;
                    up_next   = 1'b0;
                end
                state_next = ST_TICK_STEP;
            end

            ST_TICK_STEP:
            begin
                if (!cfg.glide_on || (diff_reg < step_x))
                begin
                    pitch_next = target_reg;
                end
                else if (up_reg)
                begin
                    pitch_next = pitch_reg + step_x;
                end
                else
                begin
                    pitch_next = pitch_reg - step_x;
                end
                state_next = ST_DONE;
            end

            ST_SCAN:
            begin
                // Read data holds entry idx; the next entry is fetched speculatively.
                rd_ptr = idx_x + CWX'(1);
                if (mem_rdata == note_reg)
                begin
                    state_next = ST_SHIFT;
                end
                else if ((idx_x + CWX'(1)) < cnt_x)
                begin
                    idx_next = idx_reg + CW'(1);
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_SHIFT:
            begin
                // Read data holds entry idx + 1; it moves down into slot idx.
                rd_ptr = idx_x + CWX'(2);
                if ((idx_x + CWX'(1)) < cnt_x)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = idx_reg[AW-1:0];
                    mem_wdata = mem_rdata;
                    idx_next  = idx_reg + CW'(1);
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    if (action_reg == ACT_ON)
                    begin
                        state_next = ST_PUSH;
                    end
                    else
                    begin
                        rel_next   = (count_reg == CW'(1));
                        state_next = ST_DONE;
                    end
                end
            end

            ST_PUSH:
            begin
                mem_we     = 1'b1;
                mem_waddr  = count_reg[AW-1:0];
                mem_wdata  = note_reg;
                count_next = count_reg + CW'(1);
                state_next = (count_reg == '0) ? ST_ON_WAIT : ST_DONE;
            end

            ST_ON_WAIT:
            begin
                state_next = ST_ON_LUT;
            end

            ST_ON_LUT:
            begin
                pitch_next = lut_pitch;
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                res_load = out_free;
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        mem_raddr = (rd_ptr < DEPTH_X) ? rd_ptr[AW-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            pitch_reg <= '0;
            level_reg <= LEVEL_RST;
            trig_reg  <= 1'b0;
            rel_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pitch_reg <= pitch_next;
            level_reg <= level_next;
            trig_reg  <= trig_next;
            rel_reg   <= rel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        target_reg <= target_next;
        diff_reg   <= diff_next;
        up_reg     <= up_next;
        action_reg <= action_next;
        note_reg   <= note_next;
    end

    always_comb
    begin
        res.pitch_now   = pitch_reg;
        res.gate        = (count_reg != '0);
        res.trigger     = trig_reg;
        res.release_res = rel_reg;
        res.level       = level_reg;
    end

endmodule

// ----- design/mono_note_priority_glide_top.sv -----
// One input beat is in work at a time: the sequencer takes no new beat until it has handed
// the result of the last one to the output register. A tick reads the newest note, converts
// it and steps the pitch; a note off scans the stack and closes the gap on a match; a note
// on to a full stack first shifts out the oldest entry.
// Reset clears the note count, the pitch, the flags and glide enable, sets level to full
// velocity and the glide step to its default; the stack memory needs no clearing pass.
//
// Top level of the monophonic last-note-priority voice controller with portamento.
// Depends on mnpg_pkg, mnpg_stack_mem, mnpg_note_pitch and mnpg_seq.
module mono_note_priority_glide_top
    import mnpg_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,

    // Configuration write port: index 0 is glide_on, index 1 is glide_step.
    input  logic               cfg_we,
    input  logic               cfg_addr,
    input  logic [STEP_W-1:0]  cfg_wdata,

    // Input beats.
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         action,
    input  logic [NOTE_W-1:0]  note,
    input  logic [LEVEL_W-1:0] velocity,

    // Result beats.
    output logic               out_valid,
    input  logic               out_ready,
    output logic [PITCH_W-1:0] pitch_now,
    output logic               gate,
    output logic               trigger,
    output logic               release_res,
    output logic [LEVEL_W-1:0] level
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // The held notes live in a single-port-read, single-port-write memory; the sequencer
    // streams through it one entry per cycle when scanning for a note off or when closing
    // the gap left by a removed entry. The note-to-pitch converter is a short pipeline
    // shared by ticks (target of the newest note) and by the first note on (pitch jump).

    logic               glide_on_reg;
    logic [STEP_W-1:0]  glide_step_reg;
    glide_cfg_t         cfg;

    logic               out_valid_reg, out_valid_next;
    result_t            res_reg;
    result_t            res;
    logic               res_load;
    logic               out_free;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [NOTE_W-1:0]  mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [NOTE_W-1:0]  mem_rdata;
    logic [NOTE_W-1:0]  lut_note;
    logic [PITCH_W-1:0] lut_pitch;

    // Config registers. The user must write them only while the block is idle; unenforced.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glide_on_reg   <= 1'b0;
            glide_step_reg <= GLIDE_STEP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_GLIDE_ON:   glide_on_reg   <= cfg_wdata[0];
                CFG_GLIDE_STEP: glide_step_reg <= cfg_wdata;
                default:        glide_on_reg   <= glide_on_reg;
            endcase
        end
    end

    assign cfg.glide_on   = glide_on_reg;
    assign cfg.glide_step = glide_step_reg;

    mnpg_stack_mem #(
        .STACK_DEPTH (STACK_DEPTH),
        .AW          (AW)
    ) u_stack_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    mnpg_note_pitch u_note_pitch (
        .clk   (clk),
        .note  (lut_note),
        .pitch (lut_pitch)
    );

    mnpg_seq #(
        .STACK_DEPTH (STACK_DEPTH),
        .AW          (AW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .note      (note),
        .velocity  (velocity),
        .cfg       (cfg),
        .out_free  (out_free),
        .res_load  (res_load),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .lut_note  (lut_note),
        .lut_pitch (lut_pitch)
    );

    // Output register: the sequencer may accept and work on the next beat while a finished
    // result still waits here; it only stalls when it has another result to hand over.
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pitch_now   = res_reg.pitch_now;
    assign gate        = res_reg.gate;
    assign trigger     = res_reg.trigger;
    assign release_res = res_reg.release_res;
    assign level       = res_reg.level;

`ifndef SYNTH
    // An accepted beat always puts the sequencer to work, so it cannot take another at once.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted on two consecutive cycles");

    // A result is only handed over when the output register is free to take it.
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> (!out_valid_reg || out_ready))
        else $error("result overwrote a beat still waiting at the output");

    // A note on always leaves at least one held note.
    a_trigger_gate: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && trigger |-> gate)
        else $error("note on reported with the gate closed");

    // A release means the stack is empty, so the gate must be closed.
    a_release_gate: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && release_res |-> !gate)
        else $error("release reported while notes are still held");
`endif

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for mono_note_priority_glide_top: holds a scoreboard class with its
// own note stack and glide predictor, plus tasks that drive beats and write the glide registers.
// Depends on mnpg_pkg and the RTL under design/.

// The scoreboard keeps its own copy of the note stack, glide pitch, level and glide settings.
// It predicts one result beat per accepted input beat and compares result beats in order.
class glide_scoreboard;
    bit [mnpg_pkg::NOTE_W-1:0]  held [mnpg_pkg::STACK_DEPTH_DEF];
    int unsigned                held_cnt;
    bit [mnpg_pkg::PITCH_W-1:0] pitch;
    bit [mnpg_pkg::LEVEL_W-1:0] last_vel;
    bit                         glide_en;
    bit [mnpg_pkg::STEP_W-1:0]  step;
    mnpg_pkg::result_t          pending_q [$];
    int unsigned                errors;
    int unsigned                checked;
    int unsigned                n_act [4];
    int unsigned                n_full;
    int unsigned                n_release;

    function new();
        held_cnt = 0;
        pitch    = '0;
        last_vel = mnpg_pkg::LEVEL_RST;
        glide_en = 1'b0;
        step     = mnpg_pkg::GLIDE_STEP_RST;
    endfunction

    function void set_glide(bit on, bit [mnpg_pkg::STEP_W-1:0] st);
        glide_en = on;
        step     = st;
    endfunction

    // Pitch of a MIDI note in Q14.18 Hz: the top-octave value for the semitone, shifted down
    // by the octave distance with round to nearest.
    function bit [31:0] note_freq(bit [6:0] n);
        bit [63:0]   v;
        int unsigned k;
        case (n % 12)
            0:       v = 64'd2194674310;
            1:       v = 64'd2325176436;
            2:       v = 64'd2463438621;
            3:       v = 64'd2609922305;
            4:       v = 64'd2765116361;
            5:       v = 64'd2929538736;
            6:       v = 64'd3103738174;
            7:       v = 64'd3288296050;
            8:       v = 64'd3483828309;
            9:       v = 64'd3690987520;
            10:      v = 64'd3910465059;
            default: v = 64'd4142993412;
        endcase
        k = 10 - (n / 12);
        if (k > 0)
            v = v + (64'd1 << (k - 1));
        return v[31:0] >> k;
    endfunction

    function void drop_at(int unsigned pos);
        for (int unsigned i = pos; i + 1 < held_cnt; i++)
            held[i] = held[i + 1];
        held_cnt--;
    endfunction

    function void accept_beat(bit [1:0] act, bit [6:0] n, bit [6:0] vel);
        mnpg_pkg::result_t r;
        bit [31:0]         target;
        bit [31:0]         span;
        bit                found;
        bit                trig;
        bit                rel;
        trig = 1'b0;
        rel  = 1'b0;
        n_act[act]++;
        case (act)
            mnpg_pkg::ACT_TICK:
            begin
                target = pitch;
                if (held_cnt > 0)
                    target = note_freq(held[held_cnt - 1]);
                if (glide_en)
                begin
                    span = (target > pitch) ? target - pitch : pitch - target;
                    if (span < step)
                        pitch = target;
                    else if (pitch < target)
                        pitch = pitch + step;
                    else
                        pitch = pitch - step;
                end
                else
                    pitch = target;
            end
            mnpg_pkg::ACT_ON:
            begin
                if (held_cnt >= mnpg_pkg::STACK_DEPTH_DEF)
                begin
                    drop_at(0);
                    n_full++;
                end
                held[held_cnt] = n;
                held_cnt++;
                if (held_cnt == 1)
                    pitch = note_freq(n);
                last_vel = vel;
                trig = 1'b1;
            end
            mnpg_pkg::ACT_OFF:
            begin
                found = 1'b0;
                for (int unsigned i = 0; i < held_cnt && !found; i++)
                begin
                    if (held[i] == n)
                    begin
                        drop_at(i);
                        found = 1'b1;
                    end
                end
                rel = (held_cnt == 0);
                if (rel)
                    n_release++;
            end
            default: ;
        endcase
        r.pitch_now   = pitch;
        r.gate        = (held_cnt > 0);
        r.trigger     = trig;
        r.release_res = rel;
        r.level       = last_vel;
        pending_q.insert(pending_q.size(), r);
    endfunction

    function void report(string what);
        $display("[%0t] MISMATCH %s", $time, what);
        errors++;
    endfunction

    function void cmp_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report($sformatf("result %0d %s: got %0h, want %0h", checked, name, got, want));
    endfunction

    function void check_result(mnpg_pkg::result_t got);
        mnpg_pkg::result_t want;
        if (pending_q.size() == 0)
        begin
            report($sformatf("result beat with nothing outstanding, pitch_now %0h",
                             got.pitch_now));
            return;
        end
        want = pending_q.pop_front();
        cmp_field("pitch_now", got.pitch_now, want.pitch_now);
        cmp_field("gate", 32'(got.gate), 32'(want.gate));
        cmp_field("trigger", 32'(got.trigger), 32'(want.trigger));
        cmp_field("release_res", 32'(got.release_res), 32'(want.release_res));
        cmp_field("level", 32'(got.level), 32'(want.level));
        checked++;
    endfunction
endclass

module tb_top;
    import mnpg_pkg::*;

    // Action code 3 has no meaning in the block; it must leave all state alone.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic               cfg_addr;
    logic [STEP_W-1:0]  cfg_wdata;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         action;
    logic [NOTE_W-1:0]  note;
    logic [LEVEL_W-1:0] velocity;
    logic               out_valid;
    logic               out_ready;
    logic [PITCH_W-1:0] pitch_now;
    logic               gate;
    logic               trigger;
    logic               release_res;
    logic [LEVEL_W-1:0] level;

    glide_scoreboard book = new();

    // When steady is set neither side inserts gaps, so beats go back to back.
    bit          steady;
    int unsigned hold_left;
    int unsigned n_settings;

    mono_note_priority_glide_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .note        (note),
        .velocity    (velocity),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pitch_now   (pitch_now),
        .gate        (gate),
        .trigger     (trigger),
        .release_res (release_res),
        .level       (level)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Gap lengths: mostly none, often a few cycles, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [6:0] rand7();
        return 7'($urandom_range(0, 127));
    endfunction

    // Notes are drawn from two narrow bands much of the time, so that duplicates, matching
    // note offs and close pitches (which let a glide land on its target) come up often.
    function automatic logic [6:0] pick_note();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return 7'($urandom_range(0, 11));
        if (r < 55)
            return 7'($urandom_range(58, 66));
        return rand7();
    endfunction

    // The receiver stalls at random unless the run is in a steady stretch. Ready is driven
    // on the falling edge and the result beat is taken on the rising edge.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (steady)
            out_ready <= 1'b1;
        else if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                hold_left <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            book.check_result(result_t'({pitch_now, gate, trigger, release_res, level}));
    end

    // Sends one input beat. Called on a falling edge and returns on a falling edge. Within this
    // task the valid line is only lowered by a gap, so back-to-back beats keep it high.
    task automatic send_beat(input logic [1:0] a, input logic [6:0] n, input logic [6:0] v);
        int unsigned gap_len;
        gap_len = steady ? 0 : pick_gap();
        if (gap_len != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap_len) @(negedge clk);
        end
        in_valid <= 1'b1;
        action   <= a;
        note     <= n;
        velocity <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        book.accept_beat(a, n, v);
        @(negedge clk);
    endtask

    // Holds off the sender until every outstanding result beat has come back.
    task automatic drain();
        in_valid <= 1'b0;
        while (book.pending_q.size() != 0)
            @(negedge clk);
    endtask

    // Writes both glide registers, only once the block is idle. The glide_on write carries
    // random upper bits, which the block must ignore.
    task automatic write_glide(input bit on, input logic [STEP_W-1:0] st);
        logic [STEP_W-2:0] junk;
        junk = (STEP_W-1)'($urandom);
        drain();
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_GLIDE_ON;
        cfg_wdata <= {junk, on};
        @(negedge clk);
        cfg_addr  <= CFG_GLIDE_STEP;
        cfg_wdata <= st;
        @(negedge clk);
        cfg_we <= 1'b0;
        book.set_glide(on, st);
        n_settings++;
    endtask

    // Directed opening, first with the reset settings (glide off, default step).
    task automatic run_directed();
        send_beat(ACT_TICK, 7'd127, 7'd127);   // empty stack: pitch holds at zero, level full
        send_beat(ACT_OFF, 7'd5, 7'd0);        // note off on an empty stack still releases
        send_beat(ACT_UNUSED, 7'd127, 7'd127); // unused code reports state only
        send_beat(ACT_ON, 7'd0, 7'd0);         // first note: pitch jumps, lowest note
        send_beat(ACT_TICK, 7'd0, 7'd0);
        send_beat(ACT_ON, 7'd127, 7'd127);     // highest note, full velocity
        send_beat(ACT_TICK, 7'd64, 7'd1);      // glide off: jump to the top note
        send_beat(ACT_ON, 7'd127, 7'd1);       // duplicate held note
        send_beat(ACT_OFF, 7'd127, 7'd99);     // removes only the oldest of the duplicates
        send_beat(ACT_TICK, 7'd0, 7'd0);
        send_beat(ACT_OFF, 7'd64, 7'd0);       // no match: stack unchanged
        send_beat(ACT_OFF, 7'd0, 7'd0);
        send_beat(ACT_UNUSED, 7'd0, 7'd0);
        send_beat(ACT_OFF, 7'd127, 7'd0);      // stack empties: release
        send_beat(ACT_TICK, 7'd3, 7'd3);       // pitch holds with nothing held
        send_beat(ACT_ON, 7'd60, 7'd100);
        write_glide(1'b1, GLIDE_STEP_RST);
        send_beat(ACT_ON, 7'd72, 7'd90);
        repeat (3) send_beat(ACT_TICK, 7'd0, 7'd0);    // slews upward by one step per tick
        send_beat(ACT_OFF, 7'd72, 7'd0);
        repeat (2) send_beat(ACT_TICK, 7'd0, 7'd0);    // slews back down
        write_glide(1'b1, '0);
        send_beat(ACT_TICK, 7'd0, 7'd0);       // zero step: pitch stays put
        send_beat(ACT_OFF, 7'd60, 7'd0);
        send_beat(ACT_ON, 7'd61, 7'd55);       // jump on first note, then a tick at target
        send_beat(ACT_TICK, 7'd0, 7'd0);
    endtask

    // Random stretch: mostly musical sequences (tick runs, note ons, note offs of held
    // notes, stack-filling bursts, full releases), with some noise mixed in.
    task automatic run_phase(input int unsigned budget);
        int unsigned sent;
        int unsigned r;
        int unsigned len;
        logic [6:0]  n;
        sent = 0;
        while (sent < budget)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                  : $urandom_range(1, 6);
                repeat (len) send_beat(ACT_TICK, rand7(), rand7());
                sent += len;
            end
            else if (r < 65)
            begin
                send_beat(ACT_ON, pick_note(), rand7());
                sent++;
            end
            else if (r < 83)
            begin
                if (book.held_cnt > 0 && $urandom_range(0, 99) < 80)
                    n = book.held[$urandom_range(0, book.held_cnt - 1)];
                else
                    n = pick_note();
                send_beat(ACT_OFF, n, rand7());
                sent++;
            end
            else if (r < 88)
            begin
                // Overfill the stack so the oldest notes get dropped.
                len = $urandom_range(STACK_DEPTH_DEF, STACK_DEPTH_DEF + 6);
                repeat (len) send_beat(ACT_ON, pick_note(), rand7());
                sent += len;
            end
            else if (r < 93)
            begin
                while (book.held_cnt > 0)
                begin
                    n = book.held[$urandom_range(0, book.held_cnt - 1)];
                    send_beat(ACT_OFF, n, rand7());
                    sent++;
                end
            end
            else if (r < 98)
            begin
                send_beat($urandom_range(0, 1) ? ACT_UNUSED : ACT_OFF, rand7(), rand7());
                sent++;
            end
            else
                drain();
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = CFG_GLIDE_ON;
        cfg_wdata = '0;
        in_valid  = 1'b0;
        action    = ACT_TICK;
        note      = '0;
        velocity  = '0;
        steady    = 1'b0;
        hold_left = 0;
        n_settings = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();

        // Eight random phases, each preceded by a glide setting write, the extremes included.
        // Two of them run with no idling on either side.
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0:       write_glide(1'b1, GLIDE_STEP_RST);
                1:       write_glide(1'b1, '0);
                2:       write_glide(1'b0, STEP_W'($urandom_range(0, 26214)));
                3:       write_glide(1'b1, 15'd1);
                5:       write_glide(1'b0, '0);
                6:       write_glide(1'b1, GLIDE_STEP_RST);
                default: write_glide(1'b1, STEP_W'($urandom_range(256, 26214)));
            endcase
            steady = (p == 2 || p == 5);
            run_phase(175);
        end
        steady = 1'b0;

        // Let the last results come back, then watch a while longer for stray beats.
        drain();
        repeat (40) @(posedge clk);

        $display("Run covered %0d input beats: %0d ticks, %0d note ons, %0d note offs, %0d unused.",
                 book.n_act[0] + book.n_act[1] + book.n_act[2] + book.n_act[3],
                 book.n_act[ACT_TICK], book.n_act[ACT_ON], book.n_act[ACT_OFF],
                 book.n_act[ACT_UNUSED]);
        $display("%0d results checked, %0d full-stack drops, %0d releases, %0d glide settings.",
                 book.checked, book.n_full, book.n_release, n_settings);
        if (book.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog: a correct run ends far sooner than this, even with every long stall.
    initial
    begin
        #10_000_000;
        $display("Timeout with %0d results outstanding", book.pending_q.size());
        $display("Simulation FAILED");
        $finish;
    end
endmodule

// ----- mono_note_priority_glide_top.f -----
design/mnpg_pkg.sv
design/mnpg_stack_mem.sv
design/mnpg_note_pitch.sv
design/mnpg_seq.sv
design/mono_note_priority_glide_top.sv
test/tb_top.sv
